@@ rtl/core/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the keypad code lock
// Payload structs, key map, lock modes and register indexes.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam int unsigned KEY_W    = 8;
	localparam int unsigned LINES_W  = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PIN_LEN  = 4;

	localparam logic [KEY_W-1:0] KEY_DOOR    = 8'h44;	// 'D'
	localparam logic [KEY_W-1:0] KEY_INVALID = 8'h49;	// 'I'

	localparam logic [CFG_IDX_W-1:0] REG_PIN_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_TWO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_THREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIN_FOUR  = 3'd3;

	localparam logic [KEY_W-1:0] PIN_ONE_RST   = 8'h35;	// '5'
	localparam logic [KEY_W-1:0] PIN_TWO_RST   = 8'h34;	// '4'
	localparam logic [KEY_W-1:0] PIN_THREE_RST = 8'h33;	// '3'
	localparam logic [KEY_W-1:0] PIN_FOUR_RST  = 8'h31;	// '1'

	typedef enum logic [1:0] {
		MODE_LOCKED    = 2'd0,
		MODE_UNLOCKING = 2'd1,
		MODE_UNLOCKED  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [LINES_W-1:0] row_lines;
		logic [LINES_W-1:0] col_lines;
	} in_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic [1:0]       lock_mode;
		logic [1:0]       digits_entered;
	} out_item_t;

	// decoded key as it sits in the queue between front and back
	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic             is_door;
	} key_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// rows 0..3, columns 0..3
	localparam logic [KEY_W-1:0] KEY_MAP [4][4] = '{
		'{8'h44, 8'h23, 8'h30, 8'h2A},	// D # 0 *
		'{8'h43, 8'h39, 8'h38, 8'h37},	// C 9 8 7
		'{8'h42, 8'h36, 8'h35, 8'h34},	// B 6 5 4
		'{8'h41, 8'h33, 8'h32, 8'h31}	// A 3 2 1
	};

	function automatic logic [1:0] top_bit(input logic [LINES_W-1:0] v);
		logic [1:0] pos;
		pos = 2'd0;
		for (int b = 0; b < LINES_W; b++) begin
			if (v[b]) pos = 2'(b);
		end
		return pos;
	endfunction

	function automatic logic [KEY_W-1:0] decode_key(input logic [LINES_W-1:0] rows,
	                                                input logic [LINES_W-1:0] cols);
		logic [KEY_W-1:0] k;
		if (rows == '0 || cols == '0) k = KEY_INVALID;
		else k = KEY_MAP[top_bit(rows)][top_bit(cols)];
		return k;
	endfunction

endpackage

@@ rtl/core/kcl_front.sv @@
// ----------------------------------------------------------------------------
// kcl_front: key decode
// Turns sampled row/column lines into a key character and flags the door key.
// ----------------------------------------------------------------------------
module kcl_front (
	input  kcl_pkg::in_item_t   din,
	input  logic                push,
	input  kcl_pkg::q_status_t  q_status,
	output logic                full,
	output logic                q_push,
	output kcl_pkg::key_entry_t q_data
);

	logic [kcl_pkg::KEY_W-1:0] key;

	always_comb begin
		key              = kcl_pkg::decode_key(din.row_lines, din.col_lines);
		q_data.key_code  = key;
		q_data.is_door   = (key == kcl_pkg::KEY_DOOR);
		full             = q_status.full;
		q_push           = push && !q_status.full;
	end

endmodule

@@ rtl/core/kcl_fifo.sv @@
// ----------------------------------------------------------------------------
// kcl_fifo: two-entry key queue
// Decouples decode from the lock machine; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module kcl_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kcl_pkg::key_entry_t wdata,
	input  logic                pop,
	output kcl_pkg::key_entry_t rdata,
	output kcl_pkg::q_status_t  status
);

	kcl_pkg::key_entry_t mem_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;

	logic do_push;
	logic do_pop;

	assign do_push      = push && (cnt_q != 2'd2);
	assign do_pop       = pop && (cnt_q != 2'd0);
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign rdata        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("key queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("key queue pointers out of step");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("key queue lost a beat");
`endif

endmodule

@@ rtl/core/kcl_back.sv @@
// ----------------------------------------------------------------------------
// kcl_back: lock machine and result queue
// Holds PIN registers, lock mode and digit slots; results wait in a
// two-entry output queue.
// ----------------------------------------------------------------------------
module kcl_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kcl_pkg::key_entry_t                  kdata,
	input  kcl_pkg::q_status_t                   q_status,
	output logic                                 q_pop,
	input  logic                                 cfg_valid,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [kcl_pkg::KEY_W-1:0]            cfg_data,
	input  logic                                 pop,
	output logic                                 empty,
	output kcl_pkg::out_item_t                   dout
);

	logic [kcl_pkg::KEY_W-1:0] pin_q [kcl_pkg::PIN_LEN];
	kcl_pkg::mode_t            mode_q;
	logic [1:0]                count_q;
	// fourth slot is never stored: the fourth key is compared as it arrives
	logic [kcl_pkg::KEY_W-1:0] slot_q [kcl_pkg::PIN_LEN-1];

	kcl_pkg::out_item_t oq_q [2];
	logic               oq_rd_q;
	logic [1:0]         oq_cnt_q;

	logic               take;
	logic               out_pop;
	logic               oq_wr;
	logic               match;
	kcl_pkg::mode_t     mode_nx;
	logic [1:0]         count_nx;
	logic               store;
	kcl_pkg::out_item_t res;

	assign out_pop = pop && (oq_cnt_q != 2'd0);
	assign empty   = (oq_cnt_q == 2'd0);
	assign dout    = oq_q[oq_rd_q];
	assign take    = !q_status.empty && ((oq_cnt_q != 2'd2) || out_pop);
	assign q_pop   = take;
	assign oq_wr   = oq_rd_q ^ oq_cnt_q[0];

	always_comb begin
		match = (slot_q[0] == pin_q[0]) && (slot_q[1] == pin_q[1]) &&
		        (slot_q[2] == pin_q[2]) && (kdata.key_code == pin_q[3]);
		mode_nx  = mode_q;
		count_nx = count_q;
		store    = 1'b0;
		case (mode_q)
			kcl_pkg::MODE_LOCKED: begin
				if (kdata.is_door) begin
					mode_nx  = kcl_pkg::MODE_UNLOCKING;
					count_nx = 2'd0;
				end
			end
			kcl_pkg::MODE_UNLOCKING: begin
				if (kdata.is_door) begin
					mode_nx  = kcl_pkg::MODE_LOCKED;
					count_nx = 2'd0;
				end else begin
					store = (count_q != 2'd3);
					if (count_q == 2'd3) begin
						if (match) mode_nx = kcl_pkg::MODE_UNLOCKED;
						count_nx = 2'd0;
					end else begin
						count_nx = count_q + 2'd1;
					end
				end
			end
			default: begin
				mode_nx  = kcl_pkg::MODE_UNLOCKED;
				count_nx = 2'd0;
			end
		endcase
		res.key_code       = kdata.key_code;
		res.lock_mode      = mode_nx;
		res.digits_entered = (mode_nx == kcl_pkg::MODE_UNLOCKING) ? count_nx : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q[0] <= kcl_pkg::PIN_ONE_RST;
			pin_q[1] <= kcl_pkg::PIN_TWO_RST;
			pin_q[2] <= kcl_pkg::PIN_THREE_RST;
			pin_q[3] <= kcl_pkg::PIN_FOUR_RST;
			mode_q   <= kcl_pkg::MODE_LOCKED;
			count_q  <= 2'd0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					kcl_pkg::REG_PIN_ONE:   pin_q[0] <= cfg_data;
					kcl_pkg::REG_PIN_TWO:   pin_q[1] <= cfg_data;
					kcl_pkg::REG_PIN_THREE: pin_q[2] <= cfg_data;
					kcl_pkg::REG_PIN_FOUR:  pin_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				mode_q  <= mode_nx;
				count_q <= count_nx;
			end
			if (out_pop) oq_rd_q <= ~oq_rd_q;
			oq_cnt_q <= oq_cnt_q + {1'b0, take} - {1'b0, out_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (take && store) slot_q[count_q] <= kdata.key_code;
		if (take) oq_q[oq_wr] <= res;
	end

`ifndef SYNTH
	a_unlocked_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == kcl_pkg::MODE_UNLOCKED) |=> (mode_q == kcl_pkg::MODE_UNLOCKED))
		else $error("lock left unlocked state");
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != kcl_pkg::MODE_UNLOCKING) |-> (count_q == 2'd0))
		else $error("digit count held outside unlocking");
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q != 2'd3) else $error("result queue overflow");
	a_locked_door: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_q == kcl_pkg::MODE_LOCKED && kdata.is_door)
		|=> (mode_q == kcl_pkg::MODE_UNLOCKING))
		else $error("door key ignored while locked");
`endif

endmodule

@@ rtl/core/keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock: 4x4 keypad decoder with PIN code lock
// Decodes one key press per beat and runs the lock machine on it.
//
//   channel  handshake           payload
//   input    push / full         din  (row_lines, col_lines)
//   result   pop / empty         dout (key_code, lock_mode, digits_entered)
//   config   cfg_valid/cfg_ready cfg_index, cfg_data (PIN bytes 0..3)
//
// One key per cycle sustained while the result side keeps popping; a pushed
// key is written into the key queue, then into the result queue that drives dout.
// The key queue and the result queue hold two beats each, so a stalled
// result side fills both before full rises.
// Reset loads the default PIN 5431, lock locked, both queues empty.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module keypad_code_lock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  kcl_pkg::in_item_t             din,
	output logic                          empty,
	input  logic                          pop,
	output kcl_pkg::out_item_t            dout,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcl_pkg::KEY_W-1:0]     cfg_data
);

	kcl_pkg::q_status_t  q_status;
	kcl_pkg::key_entry_t q_wdata;
	kcl_pkg::key_entry_t q_rdata;
	logic                q_push;
	logic                q_pop;

	assign cfg_ready = 1'b1;

	kcl_front u_front (
		.din      (din),
		.push     (push),
		.q_status (q_status),
		.full     (full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	kcl_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	kcl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.kdata     (q_rdata),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop       (pop),
		.empty     (empty),
		.dout      (dout)
	);

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for keypad_code_lock
// Drives key presses through the queue handshake, predicts each decoded key
// and lock state, and checks every result beat in order. PIN settings are
// changed between phases, the last of which opens the lock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import kcl_pkg::*;

class lock_scoreboard;
	string      key_rows [4];
	mode_t      mode;
	logic [1:0] held;
	logic [7:0] slots [4];
	logic [7:0] pin [4];
	out_item_t  expected_q [$];
	int         errors;
	int         checked;
	int         unlocks;

	function new();
		// row line 0..3 down, column line 0..3 across
		key_rows = '{"D#0*", "C987", "B654", "A321"};
		pin      = '{PIN_ONE_RST, PIN_TWO_RST, PIN_THREE_RST, PIN_FOUR_RST};
		slots    = '{8'h00, 8'h00, 8'h00, 8'h00};
		mode     = MODE_LOCKED;
		held     = 2'd0;
	endfunction

	function int top_line(logic [3:0] v);
		top_line = -1;
		for (int b = 0; b < 4; b++)
			if (v[b]) top_line = b;
	endfunction

	function logic [7:0] decode(in_item_t it);
		int r;
		int c;
		r = top_line(it.row_lines);
		c = top_line(it.col_lines);
		if (r < 0 || c < 0) return KEY_INVALID;
		return key_rows[r][c];
	endfunction

	// lines that decode to ch, with random lines below the chosen ones
	function bit find_key(input logic [7:0] ch, output in_item_t it);
		it = in_item_t'($urandom_range(0, 255));
		if (ch == KEY_INVALID) begin
			if ($urandom_range(0, 1)) it.row_lines = '0;
			else it.col_lines = '0;
			return 1'b1;
		end
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (key_rows[r][c] == ch) begin
					it.row_lines = (it.row_lines & 4'((1 << r) - 1)) | 4'(1 << r);
					it.col_lines = (it.col_lines & 4'((1 << c) - 1)) | 4'(1 << c);
					return 1'b1;
				end
		return 1'b0;
	endfunction

	function void write_pin(logic [2:0] idx, logic [7:0] data);
		case (idx)
			REG_PIN_ONE:   pin[0] = data;
			REG_PIN_TWO:   pin[1] = data;
			REG_PIN_THREE: pin[2] = data;
			REG_PIN_FOUR:  pin[3] = data;
			default: ;
		endcase
	endfunction

	function void note_key(in_item_t it);
		logic [7:0] k;
		out_item_t  e;
		k = decode(it);
		case (mode)
			MODE_LOCKED: begin
				if (k == KEY_DOOR) begin
					mode = MODE_UNLOCKING;
					held = 2'd0;
				end
			end
			MODE_UNLOCKING: begin
				if (k == KEY_DOOR) begin
					mode = MODE_LOCKED;
					held = 2'd0;
				end else begin
					slots[held] = k;
					if (held == 2'd3) begin
						if (slots[0] == pin[0] && slots[1] == pin[1] &&
						    slots[2] == pin[2] && slots[3] == pin[3]) begin
							mode = MODE_UNLOCKED;
							unlocks++;
						end
						held = 2'd0;
					end else begin
						held = held + 2'd1;
					end
				end
			end
			default: begin
				mode = MODE_UNLOCKED;
				held = 2'd0;
			end
		endcase
		e.key_code       = k;
		e.lock_mode      = mode;
		e.digits_entered = (mode == MODE_UNLOCKING) ? held : 2'd0;
		expected_q.push_back(e);
	endfunction

	task report(string what, logic [7:0] got, logic [7:0] want);
		errors++;
		if (errors <= 30)
			$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	task check_result(out_item_t got);
		out_item_t e;
		if (expected_q.size() == 0) begin
			report("result beat with nothing pending", got.key_code, 8'h00);
			return;
		end
		e = expected_q.pop_front();
		checked++;
		if (got.key_code !== e.key_code)
			report("key_code", got.key_code, e.key_code);
		if (got.lock_mode !== e.lock_mode)
			report("lock_mode", 8'(got.lock_mode), 8'(e.lock_mode));
		if (got.digits_entered !== e.digits_entered)
			report("digits_entered", 8'(got.digits_entered), 8'(e.digits_entered));
	endtask
endclass

module tb_top;

	localparam int IDLE_LIMIT = 2000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	in_item_t             din       = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	out_item_t            dout;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]     cfg_data  = '0;

	lock_scoreboard sb;
	int  sent         = 0;
	int  pin_sets     = 0;
	int  stray_writes = 0;
	int  idle_cycles  = 0;
	bit  send_calm    = 1'b0;
	bit  take_calm    = 1'b0;
	bit  in_attempt   = 1'b0;	// lock is in the unlocking state as far as stimulus knows

	always #5 clk = ~clk;

	keypad_code_lock u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.din       (din),
		.empty     (empty),
		.pop       (pop),
		.dout      (dout),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// beat monitor and watchdog
	always @(posedge clk) begin
		bit beat_seen;
		if (arst_n) begin
			beat_seen = 1'b0;
			if (push && !full) begin
				sb.note_key(din);
				beat_seen = 1'b1;
			end
			if (pop && !empty) begin
				sb.check_result(dout);
				beat_seen = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_pin(cfg_index, cfg_data);
				beat_seen = 1'b1;
			end
			idle_cycles = beat_seen ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("[keypad_code_lock] ERROR");
				$finish;
			end
		end
	end

	// result side
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			gap = take_calm ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	function automatic logic [7:0] pool_key();
		logic [7:0] ch;
		if ($urandom_range(0, 15) == 0) return KEY_INVALID;
		do ch = sb.key_rows[$urandom_range(0, 3)][$urandom_range(0, 3)];
		while (ch == KEY_DOOR);
		return ch;
	endfunction

	task send_key(in_item_t it);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		din  <= it;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task press(logic [7:0] ch);
		in_item_t it;
		void'(sb.find_key(ch, it));
		send_key(it);
	endtask

	// hold off the sender until every pending key has come back
	task settle();
		push <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task program_pin(input logic [7:0] p [4]);
		logic [CFG_IDX_W-1:0] reg_idx [4];
		int off;
		int k;
		reg_idx = '{REG_PIN_ONE, REG_PIN_TWO, REG_PIN_THREE, REG_PIN_FOUR};
		off = $urandom_range(0, 3);
		cfg_valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			k = (i + off) % 4;
			// writes past the last PIN register must be dropped
			if (stray_writes == 0 || $urandom_range(0, 3) == 0) begin
				cfg_index <= CFG_IDX_W'(REG_PIN_FOUR + 1 + $urandom_range(0, 3));
				cfg_data  <= 8'($urandom);
				do @(posedge clk); while (!cfg_ready);
				stray_writes++;
			end
			cfg_index <= reg_idx[k];
			cfg_data  <= p[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		pin_sets++;
	endtask

	// four digits while unlocking; never the right code, sometimes cut short by 'D'
	task try_code();
		logic [7:0] code [4];
		in_item_t   scratch;
		int         slot;
		int         cut;
		bit         same;
		same = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 4) != 0 && sb.find_key(sb.pin[i], scratch))
				code[i] = sb.pin[i];
			else
				code[i] = pool_key();
			same &= (code[i] == sb.pin[i]);
		end
		if (same) begin
			slot = $urandom_range(0, 3);
			do code[slot] = pool_key(); while (code[slot] == sb.pin[slot]);
		end
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
		for (int i = 0; i < cut; i++) press(code[i]);
		if (cut < 4) begin
			press(KEY_DOOR);
			in_attempt = 1'b0;
		end
	endtask

	task run_phase(int n);
		int       stop;
		int       half;
		bit       paused;
		in_item_t it;
		stop   = sent + n;
		half   = sent + n / 2;
		paused = 1'b0;
		while (sent < stop) begin
			if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
			if (!paused && sent >= half) begin
				settle();
				paused = 1'b1;
			end
			if (!in_attempt) begin
				if ($urandom_range(0, 3) == 0) begin
					do it = in_item_t'($urandom_range(0, 255));
					while (sb.decode(it) == KEY_DOOR);
					send_key(it);
				end else begin
					press(KEY_DOOR);
					in_attempt = 1'b1;
				end
			end else begin
				try_code();
				if (in_attempt && $urandom_range(0, 2) == 0) begin
					press(KEY_DOOR);
					in_attempt = 1'b0;
				end
			end
		end
	endtask

	initial begin
		logic [7:0] pin_set [4];
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: row lines in the high nibble, column lines in the low one
		send_key(in_item_t'(8'h00));	// nothing pressed
		send_key(in_item_t'(8'hF0));	// no column
		send_key(in_item_t'(8'h0F));	// no row
		send_key(in_item_t'(8'hFF));	// all lines, top ones win
		press("5");
		send_key(in_item_t'(8'h11));	// 'D' opens the entry
		press(KEY_DOOR);	// and closes it again
		press(KEY_DOOR);
		press("5"); press("4"); press("3"); press("2");	// near miss on the default PIN
		send_key(in_item_t'(8'h0A));	// invalid key taken as a digit
		press("#"); press("0"); press("*");
		press("5"); press("4");
		press(KEY_DOOR);	// abort mid code
		send_key(in_item_t'(8'h88));
		press("1");

		settle();
		program_pin('{8'h00, 8'h00, 8'h00, 8'h00});
		run_phase(300);
		settle();
		program_pin('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		run_phase(300);
		settle();
		for (int i = 0; i < 4; i++) pin_set[i] = 8'($urandom);
		program_pin(pin_set);
		run_phase(300);
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			for (int i = 0; i < 4; i++) pin_set[i] = pool_key();
			if (ph == 2) pin_set[$urandom_range(0, 3)] = KEY_INVALID;
			program_pin(pin_set);
			run_phase(300);
		end

		// last phase: enter the right code, then the lock must stay open
		settle();
		for (int i = 0; i < 4; i++) pin_set[i] = pool_key();
		if ($urandom_range(0, 1)) pin_set[$urandom_range(0, 3)] = KEY_INVALID;
		program_pin(pin_set);
		if (in_attempt) press(KEY_DOOR);
		press(KEY_DOOR);
		for (int i = 0; i < 4; i++) press(pin_set[i]);
		repeat (200) send_key(in_item_t'($urandom_range(0, 255)));

		settle();
		repeat (6) @(posedge clk);
		$display("run: %0d keys sent, %0d results checked, %0d mismatches",
		         sent, sb.checked, sb.errors);
		$display("run: %0d PIN settings, %0d stray register writes, lock opened %0d time(s)",
		         pin_sets, stray_writes, sb.unlocks);
		if (sb.errors == 0)
			$display("[keypad_code_lock] OK");
		else
			$display("[keypad_code_lock] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/kcl_pkg.sv
rtl/core/kcl_front.sv
rtl/core/kcl_fifo.sv
rtl/core/kcl_back.sv
rtl/core/keypad_code_lock.sv
dv/tb_top.sv
